// File: rtl/core/max_min_spacing_search_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spacing search core
// Shared concurrent property wrappers.
// ----------------------------------------------------------------------------
`ifndef MAX_MIN_SPACING_SEARCH_CORE_MACROS_SVH
`define MAX_MIN_SPACING_SEARCH_CORE_MACROS_SVH
// invariant checked on every rising clock edge outside reset
`define MMS_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// next-cycle implication
`define MMS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// File: rtl/core/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Shared constants and types for the spacing search core.
// ----------------------------------------------------------------------------
package mms_pkg;
   localparam int unsigned MMS_MAX_POINTS    = 1024;
   localparam int unsigned MMS_POSITION_BITS = 32;
   localparam int unsigned MMS_COUNT_BITS    = 11;
   localparam logic [MMS_COUNT_BITS-1:0] MMS_PICK_RESET = 11'd2;

   typedef enum logic [8:0] {
      ST_LOAD   = 9'b000000001,
      ST_SHIFT  = 9'b000000010,
      ST_SPAN0  = 9'b000000100,
      ST_SPAN1  = 9'b000001000,
      ST_MID    = 9'b000010000,
      ST_FIRST  = 9'b000100000,
      ST_WALK   = 9'b001000000,
      ST_DECIDE = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;
endpackage

// File: rtl/core/max_min_spacing_search_core.sv
// ----------------------------------------------------------------------------
// max_min_spacing_search_core
// Largest minimum spacing search over a loaded point set.
// ----------------------------------------------------------------------------
// Points load with req_start while busy is low. A point that is not last is
// placed by insertion sort through the point RAM, one shift per cycle, moving
// each stored point above it up one place; the first point of a set is written
// directly. A last point is inserted the same way (dropped if the store is full)
// and then starts the search: setup states SPAN0, SPAN1 and MID, then about
// log2(max-min) + 1 passes, each reading the stored points in order until the
// check is settled, then DECIDE and DONE to emit. rsp_valid pulses one cycle
// with best_spacing and cannot be stalled. csr_ready is high unless busy.
module max_min_spacing_search_core
   import mms_pkg::*;
#(
   parameter int unsigned MAX_POINTS    = MMS_MAX_POINTS,
   parameter int unsigned POSITION_BITS = MMS_POSITION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      busy,
   input  logic [POSITION_BITS-1:0]  req_position,
   input  logic                      req_last_point,
   output logic                      rsp_valid,
   output logic [POSITION_BITS-1:0]  rsp_best_spacing,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [MMS_COUNT_BITS-1:0] csr_pick_count
);
`include "max_min_spacing_search_core_macros.svh"
   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam int unsigned CW = $clog2(MAX_POINTS + 1);
   localparam int unsigned PW = POSITION_BITS;

   state_type state_ff, state_in;
   logic [MMS_COUNT_BITS-1:0] pick_ff, pick_in;
   logic [CW-1:0] total_ff, total_in, idx_ff, idx_in;
   logic [PW-1:0] pos_ff, pos_in, minv_ff, minv_in, last_ff, last_in;
   logic          flag_ff, flag_in, ok_ff, ok_in;
   logic [PW:0]   lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW:0]   picked_ff, picked_in;
   logic          rv_ff, rv_in;
   logic [PW-1:0] res_ff, res_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [PW-1:0] wr_data, rd_data;
   logic [PW:0]   sum;

   mms_point_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign busy      = (state_ff != ST_LOAD);
   assign csr_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rv_ff;
   assign rsp_best_spacing = res_ff;
   assign sum = lo_ff + hi_ff;

   always_comb begin
      state_in = state_ff; pick_in = pick_ff; total_in = total_ff; idx_in = idx_ff;
      pos_in = pos_ff; minv_in = minv_ff; last_in = last_ff; flag_in = flag_ff;
      ok_in = ok_ff; lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      picked_in = picked_ff; rv_in = 1'b0; res_in = res_ff;
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         ST_LOAD: begin
            if (csr_valid) pick_in = csr_pick_count;
            if (req_start) begin
               pos_in = req_position; flag_in = req_last_point;
               if (total_ff >= CW'(MAX_POINTS)) begin
                  state_in = req_last_point ? ST_SPAN0 : ST_LOAD;
                  idx_in = '0;
               end else if (total_ff == '0) begin
                  wr_en = 1'b1; wr_addr = '0; wr_data = req_position;
                  total_in = CW'(1);
                  idx_in = '0;
                  state_in = req_last_point ? ST_SPAN0 : ST_LOAD;
               end else begin
                  idx_in = total_ff; rd_addr = AW'(total_ff - CW'(1));
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // rd_data holds entry idx-1
            if (rd_data > pos_ff) begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
               idx_in = idx_ff - CW'(1);
               rd_addr = AW'(idx_ff - CW'(2));
               if (idx_ff == CW'(1)) begin
                  wr_en = 1'b1; wr_data = rd_data;
                  state_in = ST_SHIFT;
               end
            end
            if (!(rd_data > pos_ff) || idx_ff == '0) begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = pos_ff;
               idx_in = '0; total_in = total_ff + CW'(1);
               state_in = flag_ff ? ST_SPAN0 : ST_LOAD;
            end else if (idx_ff == CW'(1)) begin
               // entry 0 moved to 1; place point at 0 next
               idx_in = '0;
            end
         end
         ST_SPAN0: begin
            rd_addr = '0; state_in = ST_SPAN1;
         end
         ST_SPAN1: begin
            minv_in = rd_data;
            rd_addr = AW'(total_ff - CW'(1));
            state_in = ST_MID;
         end
         ST_MID: begin
            if (state_ff == ST_MID && idx_ff == '0) begin
               idx_in = CW'(1);
               lo_in = (PW+1)'(1);
               hi_in = {1'b0, rd_data - minv_ff};
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (lo_ff > hi_ff) begin
               res_in = hi_ff[PW-1:0]; rv_in = 1'b1;
               total_in = '0; state_in = ST_DONE;
            end else begin
               mid_in = sum >> 1;
               rd_addr = '0; state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            last_in = rd_data; picked_in = (CW+1)'(1); ok_in = 1'b0;
            idx_in = CW'(1); rd_addr = AW'(1);
            state_in = (total_ff > CW'(1)) ? ST_WALK : ST_DONE;
            if (total_ff <= CW'(1)) begin
               hi_in = mid_ff - (PW+1)'(1); state_in = ST_DECIDE;
            end
         end
         ST_WALK: begin
            if ({1'b0, rd_data - last_ff} >= mid_ff) begin
               picked_in = picked_ff + (CW+1)'(1); last_in = rd_data;
            end
            if (ok_ff || picked_in >= (CW+1)'(pick_ff)) begin
               lo_in = mid_ff + (PW+1)'(1); state_in = ST_DECIDE;
            end else if (idx_ff + CW'(1) >= total_ff) begin
               hi_in = mid_ff - (PW+1)'(1); state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + CW'(1);
               rd_addr = AW'(idx_ff + CW'(1));
            end
         end
         ST_DONE: begin
            idx_in = '0; state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; pick_ff <= MMS_PICK_RESET; total_ff <= '0;
         idx_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pick_ff <= pick_in; total_ff <= total_in;
         idx_ff <= idx_in; rv_ff <= rv_in;
      end
      pos_ff <= pos_in; minv_ff <= minv_in; last_ff <= last_in; flag_ff <= flag_in;
      ok_ff <= ok_in; lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      picked_ff <= picked_in; res_ff <= res_in;
   end

   `MMS_ASSERT_IMPL(a_total_range, clock, reset, total_ff <= CW'(MAX_POINTS), "total over depth")
   `MMS_ASSERT_NEXT(a_rsp_done, clock, reset, rv_ff, state_ff == ST_LOAD, "result not followed by load")
   `MMS_ASSERT_IMPL(a_rsp_busy, clock, reset, !rv_ff || total_ff == '0, "store not emptied")
endmodule

// File: rtl/core/mms_point_ram.sv
// ----------------------------------------------------------------------------
// mms_point_ram
// Point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mms_point_ram
   import mms_pkg::*;
#(
   parameter int unsigned DEPTH = MMS_MAX_POINTS,
   parameter int unsigned WIDTH = MMS_POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: max_min_spacing_search_core testbench
// Loads point sets word by word, predicts the largest minimum spacing of each
// set with a local insertion-sorted copy and a binary search over greedy
// checks, and compares every strobed result in order. Runs directed sets,
// then random sets under several pick counts and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
   import mms_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 4000000;

   class spacing_scoreboard;
      longint unsigned             points[$];
      logic [MMS_COUNT_BITS-1:0]   picks;
      logic [31:0]                 expected_spacings[$];

      function new();
         picks = MMS_PICK_RESET;
      endfunction

      function void set_picks(logic [MMS_COUNT_BITS-1:0] v);
         picks = v;
      endfunction

      function bit fits(longint unsigned gap);
         int unsigned     taken;
         longint unsigned prev;
         taken = 1;
         prev  = points[0];
         for (int i = 1; i < points.size(); i++) begin
            if (points[i] - prev >= gap) begin
               taken++;
               prev = points[i];
            end
            if (taken >= picks) return 1;
         end
         return 0;
      endfunction

      function void note_point(logic [31:0] pos, bit last);
         int              i;
         longint unsigned lo, hi, mid;
         i = points.size();
         if (i < MMS_MAX_POINTS) begin
            while (i > 0 && points[i-1] > pos) i--;
            points.insert(i, pos);
         end
         if (last) begin
            lo = 1;
            hi = points[$] - points[0];
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (fits(mid)) lo = mid + 1;
               else hi = mid - 1;
            end
            expected_spacings.push_back(hi[31:0]);
            points.delete();
         end
      endfunction

      function string check_spacing(logic [31:0] got);
         logic [31:0] want;
         if (expected_spacings.size() == 0)
            return $sformatf("unexpected result best_spacing=%0d", got);
         want = expected_spacings.pop_front();
         if (got !== want)
            return $sformatf("best_spacing got %0d want %0d", got, want);
         return "";
      endfunction
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_start = 0;
   logic                      busy;
   logic [31:0]               req_position = '0;
   logic                      req_last_point = 0;
   logic                      rsp_valid;
   logic [31:0]               rsp_best_spacing;
   logic                      csr_valid = 0;
   logic                      csr_ready;
   logic [MMS_COUNT_BITS-1:0] csr_pick_count = '0;

   spacing_scoreboard sb = new();
   int unsigned       errors = 0;
   int unsigned       cycles = 0;

   max_min_spacing_search_core dut (
      .clock(clock), .reset(reset), .req_start(req_start), .busy(busy),
      .req_position(req_position), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_best_spacing(rsp_best_spacing),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_pick_count(csr_pick_count)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   task automatic report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      string msg;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("max_min_spacing_search_core: mismatch");
         $finish;
      end
      if (!reset && rsp_valid) begin
         msg = sb.check_spacing(rsp_best_spacing);
         if (msg != "") report(msg);
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_point(logic [31:0] pos, bit last, int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_start <= 0;
         @(negedge clock);
      end
      req_start      <= 1;
      req_position   <= pos;
      req_last_point <= last;
      do @(posedge clock); while (busy);
      sb.note_point(pos, last);
      @(negedge clock);
   endtask

   task automatic drain();
      req_start <= 0;
      while (sb.expected_spacings.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_picks(logic [MMS_COUNT_BITS-1:0] v);
      csr_valid      <= 1;
      csr_pick_count <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_picks(v);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_set(int n, int unsigned idle_pct, bit ascending);
      int          mode;
      logic [31:0] base, pos;
      mode = $urandom_range(3);
      base = $urandom;
      for (int i = 0; i < n; i++) begin
         if (ascending) pos = i * 4099;
         else case (mode)
            0, 1: pos = $urandom;
            2: pos = base + $urandom_range(0, 60);
            default: pos = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF :
                           ($urandom_range(2) == 0) ? 32'h0 : $urandom;
         endcase
         send_point(pos, i == n - 1, idle_pct);
      end
   endtask

   initial begin
      logic [MMS_COUNT_BITS-1:0] pick_plan[8] = '{11'd0, 11'd1, 11'd3, 11'd2047,
                                                   11'd1024, 11'd5, 11'd2, 11'd4};
      int unsigned               idle_plan[4] = '{0, 82, 0, 36};
      int unsigned               sent;
      int                        r, n;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed sets at the reset pick count
      send_point(32'h0, 0, 0);
      send_point(32'hFFFF_FFFF, 1, 0);
      send_point(32'd5, 1, 0);
      send_point(32'd7, 0, 0);
      send_point(32'd7, 0, 0);
      send_point(32'd7, 1, 0);
      send_point(32'd10, 0, 0);
      send_point(32'd1, 0, 0);
      send_point(32'd4, 0, 0);
      send_point(32'd9, 1, 0);
      drain();
      write_picks(11'd3);
      send_point(32'd1, 0, 0);
      send_point(32'd2, 0, 0);
      send_point(32'd8, 0, 0);
      send_point(32'd4, 0, 0);
      send_point(32'd9, 1, 0);
      drain();
      write_picks(11'd6);
      send_point(32'hAAAA_AAAA, 0, 0);
      send_point(32'h5555_5555, 0, 0);
      send_point(32'd3, 1, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_picks(pick_plan[ph]);
         sent = 0;
         if (pick_plan[ph] == 11'd1024) begin
            // store overflow: extra points, including the last one, are dropped
            send_set(MMS_MAX_POINTS + 6, 0, 1);
            drain();
         end
         while (sent < 70) begin
            r = $urandom_range(99);
            n = (r < 70) ? $urandom_range(1, 8) :
                (r < 95) ? $urandom_range(9, 24) : $urandom_range(25, 64);
            send_set(n, idle_plan[ph % 4], 0);
            sent += n;
            if ($urandom_range(9) == 0) drain();
         end
         drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && sb.expected_spacings.size() == 0)
         $display("max_min_spacing_search_core: match");
      else begin
         if (sb.expected_spacings.size() != 0)
            report($sformatf("%0d results never arrived", sb.expected_spacings.size()));
         $display("max_min_spacing_search_core: mismatch");
      end
      $finish;
   end
endmodule
